>>> src/hag_pkg.sv
// shared types, constants and helper functions for the homeostatic gain block
package hag_pkg;

  // number of unit indexes the input field can carry
  localparam int INDEX_SPAN = 1024;

  localparam logic [16:0]        Q_ONE     = 17'h10000;
  localparam logic signed [23:0] AVG_RESET = 24'sd655;
  localparam logic signed [23:0] GAIN_RESET = 24'sd0;
  localparam logic signed [47:0] V_MAX48   = 48'sd8388607;
  localparam logic signed [47:0] V_MIN48   = -48'sd8388608;

  // item commands
  localparam logic CMD_TRACE = 1'b0;
  localparam logic CMD_APPLY = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_TRACE_RATE  = 2'd0;
  localparam logic [1:0] CFG_TRACE_FLOOR = 2'd1;
  localparam logic [1:0] CFG_GAIN_RATE   = 2'd2;
  localparam logic [1:0] CFG_TARGET_AVG  = 2'd3;

  typedef struct packed {
    logic               cmd;
    logic [9:0]         unit_index;
    logic signed [23:0] activity;
    logic               sweep_end;
  } hag_in_t;

  typedef struct packed {
    logic signed [23:0] value_out;
    logic               saturated;
  } hag_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_MULT,
    ST_FINISH
  } hag_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic clr;
    logic accept;
    logic read;
    logic diff;
    logic mul;
    logic fin;
  } hag_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
  } hag_status_t;

  // rates above one count as one
  function automatic logic [16:0] rate_clamp(input logic [16:0] v);
    rate_clamp = (v > Q_ONE) ? Q_ONE : v;
  endfunction

  // clip to signed 24 bits, flag in the top bit
  function automatic logic [24:0] sat24(input logic signed [47:0] v);
    logic [24:0] r;
    if (v > V_MAX48) begin
      r = {1'b1, V_MAX48[23:0]};
    end else if (v < V_MIN48) begin
      r = {1'b1, V_MIN48[23:0]};
    end else begin
      r = {1'b0, v[23:0]};
    end
    sat24 = r;
  endfunction

endpackage

>>> src/hag_ram.sv
// generic simple dual-port ram with registered read
module hag_ram #(
  parameter int WIDTH  = 24,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/hag_ctrl.sv
// controller state machine: clearing pass, item sequencing, output register valid
module hag_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  hag_pkg::hag_status_t status,
  output hag_pkg::hag_cmd_t    cmd
);

  hag_pkg::hag_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hag_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hag_pkg::ST_CLEAR: begin
        if (status.clr_last) state_nxt = hag_pkg::ST_IDLE;
      end
      hag_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = hag_pkg::ST_READ;
      end
      hag_pkg::ST_READ:  state_nxt = hag_pkg::ST_DIFF;
      hag_pkg::ST_DIFF:  state_nxt = hag_pkg::ST_MULT;
      hag_pkg::ST_MULT:  state_nxt = hag_pkg::ST_FINISH;
      hag_pkg::ST_FINISH: begin
        if (out_free) state_nxt = hag_pkg::ST_IDLE;
      end
      default: state_nxt = hag_pkg::ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      hag_pkg::ST_CLEAR:  cmd.clr = 1'b1;
      hag_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      hag_pkg::ST_READ:   cmd.read = 1'b1;
      hag_pkg::ST_DIFF:   cmd.diff = 1'b1;
      hag_pkg::ST_MULT:   cmd.mul  = 1'b1;
      hag_pkg::ST_FINISH: cmd.fin  = out_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> src/hag_dp.sv
// datapath: config registers, average and gain stores, multiply and saturate
module hag_dp #(
  parameter int UNIT_COUNT = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hag_pkg::hag_cmd_t    cmd,
  output hag_pkg::hag_status_t status,
  input  hag_pkg::hag_in_t     in_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [23:0]          cfg_data,
  output hag_pkg::hag_out_t    out_data
);

  localparam int DEPTH  = (UNIT_COUNT > hag_pkg::INDEX_SPAN) ? hag_pkg::INDEX_SPAN : UNIT_COUNT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [16:0]        trace_rate_r, trace_floor_r, gain_rate_r;
  logic signed [23:0] target_r;
  logic               gains_active_r;
  logic [ADDR_W-1:0]  clr_cnt_r;

  hag_pkg::hag_in_t   item_r;
  logic               in_range_r;
  logic signed [23:0] avg_r, gain_r;
  logic signed [41:0] prod_r;
  logic signed [24:0] err_r;
  logic signed [41:0] d_r;
  logic signed [38:0] ph_r;
  logic [37:0]        pl_r;
  hag_pkg::hag_out_t  out_data_r;

  logic [23:0]        avg_rd, gain_rd;
  logic [16:0]        rate;
  logic signed [17:0] floor_inv;
  logic [60:0]        psum, pr32, pr16;
  logic signed [28:0] step32;
  logic signed [44:0] step16;
  logic [24:0]        avg_sat, gain_sat, outv_sat;
  logic               is_trace;
  logic               avg_we, gain_we;
  logic [ADDR_W-1:0]  wr_addr;
  hag_pkg::hag_out_t  result;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trace_rate_r  <= 17'd655;
      trace_floor_r <= 17'd0;
      gain_rate_r   <= 17'd0;
      target_r      <= 24'sd0;
    end else if (cfg_we) begin
      case (cfg_index)
        hag_pkg::CFG_TRACE_RATE:  trace_rate_r  <= hag_pkg::rate_clamp(cfg_data[16:0]);
        hag_pkg::CFG_TRACE_FLOOR: trace_floor_r <= hag_pkg::rate_clamp(cfg_data[16:0]);
        hag_pkg::CFG_GAIN_RATE:   gain_rate_r   <= hag_pkg::rate_clamp(cfg_data[16:0]);
        hag_pkg::CFG_TARGET_AVG:  target_r      <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r      <= '0;
      gains_active_r <= 1'b0;
    end else begin
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.fin && item_r.cmd == hag_pkg::CMD_APPLY && item_r.sweep_end) begin
        gains_active_r <= 1'b1;
      end
    end
  end

  assign status.clr_last = (clr_cnt_r == ADDR_W'(DEPTH - 1));

  assign is_trace  = (item_r.cmd == hag_pkg::CMD_TRACE);
  assign rate      = is_trace ? trace_rate_r : gain_rate_r;
  assign floor_inv = $signed({1'b0, hag_pkg::Q_ONE - trace_floor_r});

  // arithmetic stages
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r     <= in_data;
      in_range_r <= ({22'd0, in_data.unit_index} < 32'(UNIT_COUNT));
    end
    if (cmd.read) begin
      avg_r  <= $signed(avg_rd);
      gain_r <= $signed(gain_rd);
      prod_r <= floor_inv * item_r.activity;
      err_r  <= {target_r[23], target_r} - {avg_rd[23], avg_rd};
    end
    if (cmd.diff) begin
      if (is_trace) begin
        d_r <= $signed(prod_r + {9'd0, trace_floor_r, 16'd0}
                       - {{2{avg_r[23]}}, avg_r, 16'd0});
      end else begin
        d_r <= {{17{err_r[24]}}, err_r};
      end
    end
    if (cmd.mul) begin
      ph_r <= $signed({1'b0, rate}) * $signed(d_r[41:21]);
      pl_r <= rate * d_r[20:0];
    end
    if (cmd.fin) begin
      out_data_r <= result;
    end
  end

  // recombine partial products and round
  assign psum   = ({{22{ph_r[38]}}, ph_r} << 21) + {23'd0, pl_r};
  assign pr32   = psum + (61'd1 << 31);
  assign pr16   = psum + (61'd1 << 15);
  assign step32 = $signed(pr32[60:32]);
  assign step16 = $signed(pr16[60:16]);

  assign avg_sat  = hag_pkg::sat24({{24{avg_r[23]}}, avg_r} + {{19{step32[28]}}, step32});
  assign gain_sat = hag_pkg::sat24({{24{gain_r[23]}}, gain_r} + {{3{step16[44]}}, step16});
  assign outv_sat = hag_pkg::sat24({{24{item_r.activity[23]}}, item_r.activity}
                                   + {{24{gain_sat[23]}}, gain_sat[23:0]});

  always_comb begin
    result.value_out = item_r.activity;
    result.saturated = 1'b0;
    avg_we           = 1'b0;
    gain_we          = 1'b0;
    if (in_range_r) begin
      if (is_trace) begin
        result.value_out = $signed(avg_sat[23:0]);
        result.saturated = avg_sat[24];
        avg_we           = cmd.fin;
      end else if (gains_active_r) begin
        result.value_out = $signed(outv_sat[23:0]);
        result.saturated = gain_sat[24] | outv_sat[24];
        gain_we          = cmd.fin;
      end
    end
  end

  assign wr_addr = cmd.clr ? clr_cnt_r : item_r.unit_index[ADDR_W-1:0];

  hag_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_avg_ram (
    .clk     (clk),
    .wr_en   (cmd.clr | avg_we),
    .wr_addr (wr_addr),
    .wr_data (cmd.clr ? hag_pkg::AVG_RESET : avg_sat[23:0]),
    .rd_en   (cmd.accept),
    .rd_addr (in_data.unit_index[ADDR_W-1:0]),
    .rd_data (avg_rd)
  );

  hag_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_gain_ram (
    .clk     (clk),
    .wr_en   (cmd.clr | gain_we),
    .wr_addr (wr_addr),
    .wr_data (cmd.clr ? hag_pkg::GAIN_RESET : gain_sat[23:0]),
    .rd_en   (cmd.accept),
    .rd_addr (in_data.unit_index[ADDR_W-1:0]),
    .rd_data (gain_rd)
  );

  assign out_data = out_data_r;

endmodule

>>> src/homeostatic_average_gain.sv
// top level of the per-unit homeostatic gain block
// usage:
//   - input channel in_valid/in_ready/in_data carries one transaction per item:
//     cmd 0 updates the unit's moving average, cmd 1 applies the unit's gain
//   - output channel out_valid/out_ready/out_data returns one transaction per
//     item: the new average or activity plus gain, with a saturation flag
//   - cfg_we/cfg_index/cfg_data write the four rate and target registers, one
//     register per write; write only while no item is in flight
//   - each item passes the read, difference, multiply and finish states; its
//     result then shows on out_valid, and the next item is taken once the block is
//     back in idle, set by the single read-modify-write of each store
//   - after reset a clearing pass writes every entry of both stores, one entry a
//     cycle, min(UNIT_COUNT, 1024) entries; in_ready stays low until it is done
//   - a finished result waits in the output register; the next item is taken
//     meanwhile, and it holds in its finish step while the receiver stalls
//   - the first sweep of apply items passes activity through; its sweep end
//     mark arms the gains for all later apply items
module homeostatic_average_gain #(
  parameter int UNIT_COUNT = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hag_pkg::hag_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hag_pkg::hag_out_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [23:0]       cfg_data
);

  // command and status between the sequencer and the datapath
  hag_pkg::hag_cmd_t    cmd;
  hag_pkg::hag_status_t status;

  hag_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // stores, config registers and the split multiplier live here
  hag_dp #(.UNIT_COUNT(UNIT_COUNT)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

>>> src/hag_checker.sv
// port-level checker for the homeostatic gain block, bound to the top level
module hag_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input hag_pkg::hag_out_t out_data
);

  // clearing pass blocks items right after reset
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("in_ready high right after reset");

  a_no_out_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // one item at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !$rose(out_valid))
    else $error("second transaction or early result after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind homeostatic_average_gain hag_checker u_hag_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> tb/homeostatic_average_gain_tb.sv
`timescale 1ns / 100ps
// testbench for the homeostatic gain block: shadow scoreboard, random handshakes, staged configs
module homeostatic_average_gain_tb;

  localparam int TIMEOUT_NS = 3_000_000;  // far beyond the slowest legal run
  localparam int HOLD_CYCLES = 400;       // long receiver stall, fills the block
  localparam int ITEMS_PER_PHASE = 200;
  localparam int REPORT_CAP = 30;         // keep the log short on a broken build
  localparam logic [16:0] TRACE_RATE_RESET = 17'd655;
  localparam logic signed [23:0] ACT_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] ACT_MIN = 24'sh800000;
  localparam longint SAT_HI = 64'sd8388607;
  localparam longint SAT_LO = -64'sd8388608;

  // outcome of matching one result against the oldest prediction
  typedef struct packed {
    logic              orphan;
    logic              value_bad;
    logic              flag_bad;
    hag_pkg::hag_out_t want;
  } match_t;

  // shadow copy of the averages, gains and registers; predicts each result
  class gain_tracker;
    logic signed [23:0] avg_mem [hag_pkg::INDEX_SPAN];
    logic signed [23:0] gain_mem [hag_pkg::INDEX_SPAN];
    bit                 armed;
    logic [16:0]        alpha;
    logic [16:0]        lambda0;
    logic [16:0]        impact;
    logic signed [23:0] aim;
    hag_pkg::hag_out_t  waiting[$];

    function new();
      for (int i = 0; i < hag_pkg::INDEX_SPAN; i++) begin
        avg_mem[i] = hag_pkg::AVG_RESET;
        gain_mem[i] = hag_pkg::GAIN_RESET;
      end
      armed = 1'b0;
      alpha = TRACE_RATE_RESET;
      lambda0 = '0;
      impact = '0;
      aim = '0;
    endfunction

    function logic [16:0] limit_rate(logic [23:0] data);
      if (data[16:0] > hag_pkg::Q_ONE) begin
        return hag_pkg::Q_ONE;
      end
      return data[16:0];
    endfunction

    function void set_reg(logic [1:0] idx, logic [23:0] data);
      case (idx)
        hag_pkg::CFG_TRACE_RATE: alpha = limit_rate(data);
        hag_pkg::CFG_TRACE_FLOOR: lambda0 = limit_rate(data);
        hag_pkg::CFG_GAIN_RATE: impact = limit_rate(data);
        hag_pkg::CFG_TARGET_AVG: aim = data;
        default: ;
      endcase
    endfunction

    // divide by 2^s, nearest, ties up
    function longint round_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint clip24(longint v, inout bit hit);
      if (v > SAT_HI) begin
        hit = 1'b1;
        return SAT_HI;
      end
      if (v < SAT_LO) begin
        hit = 1'b1;
        return SAT_LO;
      end
      return v;
    endfunction

    function void take_input(hag_pkg::hag_in_t it);
      longint h, a, l, t, d, g, r, err;
      bit hit;
      hag_pkg::hag_out_t res;
      hit = 1'b0;
      h = longint'($signed(it.activity));
      r = h;
      if (it.cmd == hag_pkg::CMD_TRACE) begin
        a = longint'(avg_mem[it.unit_index]);
        l = longint'(lambda0);
        t = (longint'(hag_pkg::Q_ONE) - l) * h + l * longint'(hag_pkg::Q_ONE);
        d = t - a * longint'(hag_pkg::Q_ONE);
        r = clip24(a + round_shift(longint'(alpha) * d, 32), hit);
        avg_mem[it.unit_index] = r[23:0];
      end else begin
        if (armed) begin
          err = longint'(aim) - longint'(avg_mem[it.unit_index]);
          g = clip24(longint'(gain_mem[it.unit_index])
                     + round_shift(longint'(impact) * err, 16), hit);
          gain_mem[it.unit_index] = g[23:0];
          r = clip24(h + g, hit);
        end
        if (it.sweep_end) begin
          armed = 1'b1;
        end
      end
      res.value_out = r[23:0];
      res.saturated = hit;
      waiting.push_back(res);
    endfunction

    function match_t match_result(hag_pkg::hag_out_t got);
      match_t m;
      m = '0;
      if (waiting.size() == 0) begin
        m.orphan = 1'b1;
        return m;
      end
      m.want = waiting.pop_front();
      m.value_bad = (got.value_out !== m.want.value_out);
      m.flag_bad = (got.saturated !== m.want.saturated);
      return m;
    endfunction

    function int pending();
      return waiting.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  hag_pkg::hag_in_t  in_data;
  logic              out_valid;
  logic              out_ready;
  hag_pkg::hag_out_t out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;

  gain_tracker tracker;
  bit idle_on;     // cleared for stretches with no gaps at all
  bit hold_req;    // asks the receiver for one long stall
  int mismatches;
  int results_seen;
  int trace_taken;
  int apply_taken;
  int clipped_seen;
  int backpressure_cycles;
  int settings_used;

  homeostatic_average_gain dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (!idle_on) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // most traffic stays on a few units so averages and gains build up
  function automatic logic [9:0] pick_unit();
    if ($urandom_range(0, 3) == 0) begin
      return 10'($urandom_range(0, 1023));
    end
    return 10'($urandom_range(0, 15));
  endfunction

  // extremes, full-range noise, and values near one
  function automatic logic signed [23:0] pick_activity();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return ACT_MAX;
    end
    if (r == 1) begin
      return ACT_MIN;
    end
    if (r <= 5) begin
      return 24'($urandom());
    end
    return 24'($signed($urandom_range(0, 262143)) - 131072);
  endfunction

  function automatic hag_pkg::hag_in_t make_item(logic cmd, logic [9:0] unit,
                                                 logic signed [23:0] act, logic last);
    hag_pkg::hag_in_t it;
    it.cmd = cmd;
    it.unit_index = unit;
    it.activity = act;
    it.sweep_end = last;
    return it;
  endfunction

  task automatic report(input string what, input hag_pkg::hag_out_t got,
                        input hag_pkg::hag_out_t want);
    mismatches++;
    if (mismatches <= REPORT_CAP) begin
      $display("[%0t] mismatch: %s (got %h/%b, want %h/%b)", $time, what,
               got.value_out, got.saturated, want.value_out, want.saturated);
    end
  endtask

  // offer one transaction after a random gap; called and returns at a falling edge
  task automatic send_item(input hag_pkg::hag_in_t it);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // write all four registers back to back; only while nothing is in flight
  task automatic write_settings(input logic [23:0] rate, input logic [23:0] floor_v,
                                input logic [23:0] gain_v, input logic [23:0] aim_v);
    logic [23:0] vals [4];
    logic [1:0]  regs [4];
    vals = '{rate, floor_v, gain_v, aim_v};
    regs = '{hag_pkg::CFG_TRACE_RATE, hag_pkg::CFG_TRACE_FLOOR, hag_pkg::CFG_GAIN_RATE,
             hag_pkg::CFG_TARGET_AVG};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      tracker.set_reg(regs[i], vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // stop offering and let every predicted result come back
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() > 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // mostly trace-then-apply sweeps, some same-unit bursts, some raw noise
  task automatic run_random(input int count);
    int sent, mode, len;
    logic [9:0] base;
    sent = 0;
    while (sent < count) begin
      mode = $urandom_range(0, 9);
      if (mode <= 5) begin
        base = pick_unit();
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          send_item(make_item(hag_pkg::CMD_TRACE, 10'(base + k), pick_activity(),
                              k == len - 1));
        end
        for (int k = 0; k < len; k++) begin
          send_item(make_item(hag_pkg::CMD_APPLY, 10'(base + k), pick_activity(),
                              k == len - 1));
        end
        sent += 2 * len;
      end else if (mode <= 7) begin
        // back-to-back on one unit exercises read after write of the stores
        base = pick_unit();
        len = $urandom_range(2, 4);
        for (int k = 0; k < len; k++) begin
          send_item(make_item(1'($urandom_range(0, 1)), base, pick_activity(),
                              1'($urandom_range(0, 1))));
        end
        sent += len;
      end else begin
        send_item(make_item(1'($urandom_range(0, 1)), 10'($urandom()), 24'($urandom()),
                            1'($urandom_range(0, 1))));
        sent += 1;
      end
    end
  endtask

  // receiver: random ready with runs and stalls, plus one long hold-off on request
  initial begin
    int stall_left, run_left;
    stall_left = 0;
    run_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
        run_left = 1;
      end
      if (stall_left == 0 && run_left == 0) begin
        stall_left = pick_gap();
        run_left = $urandom_range(1, 24);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        run_left--;
      end
    end
  end

  // sample both channels at the rising edge
  always @(posedge clk) begin
    match_t m;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_data.saturated) begin
        clipped_seen++;
      end
      m = tracker.match_result(out_data);
      if (m.orphan) begin
        report("result with no transaction pending", out_data, m.want);
      end else begin
        if (m.value_bad) begin
          report("value_out", out_data, m.want);
        end
        if (m.flag_bad) begin
          report("saturated", out_data, m.want);
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      tracker.take_input(in_data);
      if (in_data.cmd == hag_pkg::CMD_TRACE) begin
        trace_taken++;
      end else begin
        apply_taken++;
      end
    end
    if (rst_n && in_valid && !in_ready) begin
      backpressure_cycles++;
    end
  end

  // hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    tracker = new();
    idle_on = 1'b1;
    hold_req = 1'b0;
    mismatches = 0;
    results_seen = 0;
    trace_taken = 0;
    apply_taken = 0;
    clipped_seen = 0;
    backpressure_cycles = 0;
    settings_used = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: rate above one clamps, half floor, full impact, top aim
    write_settings(24'h01FFFF, 24'h008000, 24'h010000, 24'h7FFFFF);
    // gains not armed yet: apply passes activity through
    send_item(make_item(hag_pkg::CMD_APPLY, 10'd0, ACT_MAX, 1'b0));
    send_item(make_item(hag_pkg::CMD_APPLY, 10'd1, ACT_MIN, 1'b0));
    send_item(make_item(hag_pkg::CMD_TRACE, 10'd0, ACT_MAX, 1'b0));
    send_item(make_item(hag_pkg::CMD_TRACE, 10'd1, ACT_MIN, 1'b0));
    // sweep end on a trace does not arm
    send_item(make_item(hag_pkg::CMD_TRACE, 10'd1023, 24'sd0, 1'b1));
    send_item(make_item(hag_pkg::CMD_APPLY, 10'd1023, 24'sd0, 1'b0));
    // sweep end on an apply arms from the next item on
    send_item(make_item(hag_pkg::CMD_APPLY, 10'd2, 24'sh123456, 1'b1));
    // gain climbs toward the aim, output clips high
    send_item(make_item(hag_pkg::CMD_APPLY, 10'd0, ACT_MAX, 1'b0));
    send_item(make_item(hag_pkg::CMD_APPLY, 10'd0, ACT_MAX, 1'b0));
    send_item(make_item(hag_pkg::CMD_APPLY, 10'd1, ACT_MIN, 1'b0));
    // same unit back to back
    send_item(make_item(hag_pkg::CMD_TRACE, 10'd5, 24'sd0, 1'b0));
    send_item(make_item(hag_pkg::CMD_TRACE, 10'd5, 24'sd0, 1'b0));
    send_item(make_item(hag_pkg::CMD_APPLY, 10'd5, 24'sd0, 1'b0));
    send_item(make_item(hag_pkg::CMD_APPLY, 10'd5, 24'sd0, 1'b0));
    drain();

    // zero trace rate and floor, full gain rate, lowest aim: gain driven down until it clips low
    write_settings(24'h000000, 24'h000000, 24'h010000, 24'h800000);
    send_item(make_item(hag_pkg::CMD_APPLY, 10'd0, ACT_MIN, 1'b0));
    send_item(make_item(hag_pkg::CMD_APPLY, 10'd0, ACT_MIN, 1'b0));
    send_item(make_item(hag_pkg::CMD_APPLY, 10'd0, ACT_MIN, 1'b0));
    send_item(make_item(hag_pkg::CMD_TRACE, 10'd3, ACT_MAX, 1'b1));
    send_item(make_item(hag_pkg::CMD_APPLY, 10'd3, ACT_MAX, 1'b1));
    drain();

    // random phases, each under its own register setting
    for (int p = 0; p < 7; p++) begin
      idle_on = 1'b1;
      case (p)
        0: write_settings(24'd655, 24'd0, 24'd1000, 24'd655);
        1: write_settings(24'd0, 24'd0, 24'd0, 24'd0);
        2: write_settings(24'h010000, 24'h010000, 24'h010000, 24'h7FFFFF);
        3: begin
          write_settings(24'h01FFFF, 24'h01FFFF, 24'h01FFFF, 24'h800000);
          // receiver holds off while the sender keeps offering
          hold_req = 1'b1;
        end
        4: write_settings(24'($urandom()), 24'($urandom()), 24'($urandom()),
                          24'($urandom()));
        5: write_settings(24'($urandom_range(0, 4096)), 24'($urandom_range(0, 65536)),
                          24'($urandom_range(0, 65536)),
                          24'($signed($urandom_range(0, 262143)) - 131072));
        default: begin
          // a stretch with no idling on either side
          idle_on = 1'b0;
          write_settings(24'($urandom()), 24'($urandom()), 24'($urandom()),
                         24'($urandom()));
        end
      endcase
      run_random(ITEMS_PER_PHASE);
      drain();
    end

    $display("run covered %0d trace and %0d apply transactions under %0d register settings",
             trace_taken, apply_taken, settings_used);
    $display("%0d results checked, %0d clipped, %0d cycles of input back-pressure",
             results_seen, clipped_seen, backpressure_cycles);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
